### rtl/core/rgb_to_hsv_converter_assert.svh
// Assertion macros of the converter RTL, included by rgb2hsv_fix.
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define R2H_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb2hsv: check failed");

// Next-cycle implication, checked outside reset.
`define R2H_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb2hsv: check failed");

`endif

### rtl/core/rgb2hsv_pkg.sv
// Shared constants and types of the RGB to HSV converter.
package rgb2hsv_pkg;

  localparam int unsigned CHANNEL_BITS_DEF = 8;
  localparam int unsigned HUE_W            = 9;
  localparam int unsigned SAT_W            = 8;
  localparam int unsigned HUE_Q_W          = 6;
  localparam int unsigned HUE_SCALE        = 60;

  localparam logic [HUE_W-1:0] HUE_FULL  = 9'd360;
  localparam logic [HUE_W-1:0] HUE_GREEN = 9'd120;
  localparam logic [HUE_W-1:0] HUE_BLUE  = 9'd240;

  typedef enum logic [2:0] {
    SEC_RED   = 3'b001,
    SEC_GREEN = 3'b010,
    SEC_BLUE  = 3'b100
  } sector_t;

  typedef struct packed {
    sector_t sector;
    logic    neg;
    logic    gray;
  } pix_ctl_t;

endpackage

### rtl/core/rgb2hsv_ifs.sv
// Channel interfaces: RGB pixel in, hue and saturation out.
interface rgb2hsv_rgb_if #(
  parameter int unsigned CHANNEL_BITS = rgb2hsv_pkg::CHANNEL_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgb2hsv_hs_if;
  logic                            valid;
  logic                            ready;
  logic [rgb2hsv_pkg::HUE_W-1:0]   hue_degrees;
  logic [rgb2hsv_pkg::SAT_W-1:0]   saturation;

  modport source (output valid, output hue_degrees, output saturation, input ready);
  modport sink   (input valid, input hue_degrees, input saturation, output ready);
endinterface

### rtl/core/rgb2hsv_prep.sv
// Front stages: extremes, sector and difference, then scaled dividends.
module rgb2hsv_prep #(
  parameter int unsigned CHANNEL_BITS = rgb2hsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  rgb2hsv_rgb_if.sink                                 in_pix,
  output logic                                        valid_o,
  input  logic                                        ready_i,
  output rgb2hsv_pkg::pix_ctl_t                       ctl_o,
  output logic [CHANNEL_BITS-1:0]                     d_o,
  output logic [CHANNEL_BITS-1:0]                     mx_o,
  output logic [CHANNEL_BITS+rgb2hsv_pkg::HUE_Q_W-1:0] hnum_o,
  output logic [2*CHANNEL_BITS-1:0]                   snum_o
);
  import rgb2hsv_pkg::*;

  localparam int unsigned N  = CHANNEL_BITS;
  localparam int unsigned HW = N + HUE_Q_W;
  localparam int unsigned SW = 2 * N;

  // stage A: extremes and sector
  pix_ctl_t       ctl_nxt;
  logic [N-1:0]   mx, mn, p, q;
  logic           a_valid_r, a_ready;
  pix_ctl_t       a_ctl_r;
  logic [N-1:0]   a_d_r, a_mx_r, a_x_r;

  // stage B: dividends
  logic           b_valid_r, b_ready;
  pix_ctl_t       b_ctl_r;
  logic [N-1:0]   b_d_r, b_mx_r;
  logic [HW-1:0]  b_hnum_r;
  logic [SW-1:0]  b_snum_r;

  always_comb begin
    mn = in_pix.red;
    if (in_pix.green < mn) mn = in_pix.green;
    if (in_pix.blue < mn) mn = in_pix.blue;
    priority if (in_pix.red >= in_pix.green && in_pix.red >= in_pix.blue) begin
      ctl_nxt.sector = SEC_RED;
      mx = in_pix.red;
      p  = in_pix.green;
      q  = in_pix.blue;
    end else if (in_pix.green >= in_pix.blue) begin
      ctl_nxt.sector = SEC_GREEN;
      mx = in_pix.green;
      p  = in_pix.blue;
      q  = in_pix.red;
    end else begin
      ctl_nxt.sector = SEC_BLUE;
      mx = in_pix.blue;
      p  = in_pix.red;
      q  = in_pix.green;
    end
    ctl_nxt.neg  = (p < q);
    ctl_nxt.gray = (mx == mn);
  end

  assign a_ready      = !a_valid_r || b_ready;
  assign b_ready      = !b_valid_r || ready_i;
  assign in_pix.ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) a_valid_r <= in_pix.valid;
      if (b_ready) b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_ctl_r <= ctl_nxt;
      a_d_r   <= mx - mn;
      a_mx_r  <= mx;
      a_x_r   <= ctl_nxt.neg ? (q - p) : (p - q);
    end
    if (b_ready) begin
      b_ctl_r  <= a_ctl_r;
      b_d_r    <= a_d_r;
      b_mx_r   <= a_mx_r;
      b_hnum_r <= HW'(a_x_r) * HW'(HUE_SCALE);
      // d * (2^N - 1)
      b_snum_r <= {a_d_r, {N{1'b0}}} - SW'(a_d_r);
    end
  end

  assign valid_o = b_valid_r;
  assign ctl_o   = b_ctl_r;
  assign d_o     = b_d_r;
  assign mx_o    = b_mx_r;
  assign hnum_o  = b_hnum_r;
  assign snum_o  = b_snum_r;

endmodule

### rtl/core/rgb2hsv_div_step.sv
// One restoring-divide stage: resolves quotient bit STEP_BIT of hue and of saturation, each where it is in range.
module rgb2hsv_div_step #(
  parameter int unsigned CHANNEL_BITS = rgb2hsv_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned STEP_BIT     = 0
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        valid_i,
  output logic                                        ready_o,
  input  rgb2hsv_pkg::pix_ctl_t                       ctl_i,
  input  logic [CHANNEL_BITS-1:0]                     d_i,
  input  logic [CHANNEL_BITS-1:0]                     mx_i,
  input  logic [CHANNEL_BITS+rgb2hsv_pkg::HUE_Q_W-1:0] hrem_i,
  input  logic [rgb2hsv_pkg::HUE_Q_W-1:0]             hq_i,
  input  logic [2*CHANNEL_BITS-1:0]                   srem_i,
  input  logic [CHANNEL_BITS-1:0]                     sq_i,
  output logic                                        valid_o,
  input  logic                                        ready_i,
  output rgb2hsv_pkg::pix_ctl_t                       ctl_o,
  output logic [CHANNEL_BITS-1:0]                     d_o,
  output logic [CHANNEL_BITS-1:0]                     mx_o,
  output logic [CHANNEL_BITS+rgb2hsv_pkg::HUE_Q_W-1:0] hrem_o,
  output logic [rgb2hsv_pkg::HUE_Q_W-1:0]             hq_o,
  output logic [2*CHANNEL_BITS-1:0]                   srem_o,
  output logic [CHANNEL_BITS-1:0]                     sq_o
);
  import rgb2hsv_pkg::*;

  localparam int unsigned N  = CHANNEL_BITS;
  localparam int unsigned HW = N + HUE_Q_W;
  localparam int unsigned SW = 2 * N;

  logic [HW-1:0]      hrem_nxt;
  logic [HUE_Q_W-1:0] hq_nxt;
  logic [SW-1:0]      srem_nxt;
  logic [N-1:0]       sq_nxt;

  logic               valid_r;
  pix_ctl_t           ctl_r;
  logic [N-1:0]       d_r, mx_r, sq_r;
  logic [HW-1:0]      hrem_r;
  logic [HUE_Q_W-1:0] hq_r;
  logic [SW-1:0]      srem_r;

  if (STEP_BIT < HUE_Q_W) begin : g_hue
    logic [HW-1:0] hdiv;
    always_comb begin
      hdiv     = HW'(d_i) << STEP_BIT;
      hrem_nxt = hrem_i;
      hq_nxt   = hq_i;
      if (hrem_i >= hdiv) begin
        hrem_nxt         = hrem_i - hdiv;
        hq_nxt[STEP_BIT] = 1'b1;
      end
    end
  end else begin : g_hue_pass
    assign hrem_nxt = hrem_i;
    assign hq_nxt   = hq_i;
  end

  if (STEP_BIT < N) begin : g_sat
    logic [SW-1:0] sdiv;
    always_comb begin
      sdiv     = SW'(mx_i) << STEP_BIT;
      srem_nxt = srem_i;
      sq_nxt   = sq_i;
      if (srem_i >= sdiv) begin
        srem_nxt         = srem_i - sdiv;
        sq_nxt[STEP_BIT] = 1'b1;
      end
    end
  end else begin : g_sat_pass
    assign srem_nxt = srem_i;
    assign sq_nxt   = sq_i;
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o) begin
      ctl_r  <= ctl_i;
      d_r    <= d_i;
      mx_r   <= mx_i;
      hrem_r <= hrem_nxt;
      hq_r   <= hq_nxt;
      srem_r <= srem_nxt;
      sq_r   <= sq_nxt;
    end
  end

  assign valid_o = valid_r;
  assign ctl_o   = ctl_r;
  assign d_o     = d_r;
  assign mx_o    = mx_r;
  assign hrem_o  = hrem_r;
  assign hq_o    = hq_r;
  assign srem_o  = srem_r;
  assign sq_o    = sq_r;

endmodule

### rtl/core/rgb2hsv_fix.sv
// Final stage: sector offset, floor of negative hue, gray override, output register.
`include "rgb_to_hsv_converter_assert.svh"

module rgb2hsv_fix #(
  parameter int unsigned CHANNEL_BITS = rgb2hsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        valid_i,
  output logic                                        ready_o,
  input  rgb2hsv_pkg::pix_ctl_t                       ctl_i,
  input  logic [CHANNEL_BITS-1:0]                     d_i,
  input  logic [CHANNEL_BITS-1:0]                     mx_i,
  input  logic [CHANNEL_BITS+rgb2hsv_pkg::HUE_Q_W-1:0] hrem_i,
  input  logic [rgb2hsv_pkg::HUE_Q_W-1:0]             hq_i,
  input  logic [2*CHANNEL_BITS-1:0]                   srem_i,
  input  logic [CHANNEL_BITS-1:0]                     sq_i,
  rgb2hsv_hs_if.source                                out_hsv
);
  import rgb2hsv_pkg::*;

  localparam int unsigned N  = CHANNEL_BITS;
  localparam int unsigned HW = N + HUE_Q_W;
  localparam int unsigned SW = 2 * N;

  logic [HUE_W-1:0] qf, qc, hue_nxt;
  logic [SAT_W-1:0] sat_nxt;
  logic             out_valid_r;
  logic [HUE_W-1:0] hue_r;
  logic [SAT_W-1:0] sat_r;

  always_comb begin
    qf = HUE_W'(hq_i);
    // ceil of the quotient, for the negative-difference side
    qc = qf + HUE_W'(hrem_i != '0);
    unique case (ctl_i.sector)
      SEC_RED:   hue_nxt = ctl_i.neg ? (HUE_FULL - qc) : qf;
      SEC_GREEN: hue_nxt = ctl_i.neg ? (HUE_GREEN - qc) : (HUE_GREEN + qf);
      SEC_BLUE:  hue_nxt = ctl_i.neg ? (HUE_BLUE - qc) : (HUE_BLUE + qf);
      default:   hue_nxt = '0;
    endcase
    sat_nxt = SAT_W'(sq_i);
    if (ctl_i.gray) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end
  end

  assign ready_o = !out_valid_r || out_hsv.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready_o) begin
      out_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_hsv.valid       = out_valid_r;
  assign out_hsv.hue_degrees = hue_r;
  assign out_hsv.saturation  = sat_r;

  `R2H_ASSERT_IMPL(a_hue_range, out_valid_r, hue_r < HUE_FULL)
  `R2H_ASSERT_IMPL(a_rem_bound, valid_i && !ctl_i.gray, (hrem_i < HW'(d_i)) && (srem_i < SW'(mx_i)))
  `R2H_ASSERT_NEXT(a_gray_zero, valid_i && ready_o && ctl_i.gray, (hue_r == '0) && (sat_r == '0))

endmodule

### rtl/core/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter (hue and saturation).
//
//  channel   dir  beat fields                      handshake
//  in_pix    in   red, green, blue                 valid/ready
//  out_hsv   out  hue_degrees, saturation          valid/ready
//
// Throughput one pixel per cycle while out_hsv is not stalled; the divide chain
// resolves one quotient bit per stage.
// rst_n is synchronous and clears only the stage valid bits.
// Each stage holds its beat while the next one is full and stalled; empty
// stages keep taking beats, so input is accepted while a result waits.
module rgb_to_hsv_converter #(
  parameter int unsigned CHANNEL_BITS = rgb2hsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rgb2hsv_rgb_if.sink  in_pix,
  rgb2hsv_hs_if.source out_hsv
);
  import rgb2hsv_pkg::*;

  localparam int unsigned N     = CHANNEL_BITS;
  localparam int unsigned HW    = N + HUE_Q_W;
  localparam int unsigned SW    = 2 * N;
  localparam int unsigned NSTEP = (N > HUE_Q_W) ? N : HUE_Q_W;

  logic               valid_w [NSTEP+1];
  logic               ready_w [NSTEP+1];
  pix_ctl_t           ctl_w   [NSTEP+1];
  logic [N-1:0]       d_w     [NSTEP+1];
  logic [N-1:0]       mx_w    [NSTEP+1];
  logic [HW-1:0]      hrem_w  [NSTEP+1];
  logic [HUE_Q_W-1:0] hq_w    [NSTEP+1];
  logic [SW-1:0]      srem_w  [NSTEP+1];
  logic [N-1:0]       sq_w    [NSTEP+1];

  rgb2hsv_prep #(.CHANNEL_BITS(CHANNEL_BITS)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .valid_o (valid_w[0]),
    .ready_i (ready_w[0]),
    .ctl_o   (ctl_w[0]),
    .d_o     (d_w[0]),
    .mx_o    (mx_w[0]),
    .hnum_o  (hrem_w[0]),
    .snum_o  (srem_w[0])
  );

  assign hq_w[0] = '0;
  assign sq_w[0] = '0;

  for (genvar k = 0; k < NSTEP; k++) begin : g_div
    rgb2hsv_div_step #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .STEP_BIT     (NSTEP - 1 - k)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_w[k]),
      .ready_o (ready_w[k]),
      .ctl_i   (ctl_w[k]),
      .d_i     (d_w[k]),
      .mx_i    (mx_w[k]),
      .hrem_i  (hrem_w[k]),
      .hq_i    (hq_w[k]),
      .srem_i  (srem_w[k]),
      .sq_i    (sq_w[k]),
      .valid_o (valid_w[k+1]),
      .ready_i (ready_w[k+1]),
      .ctl_o   (ctl_w[k+1]),
      .d_o     (d_w[k+1]),
      .mx_o    (mx_w[k+1]),
      .hrem_o  (hrem_w[k+1]),
      .hq_o    (hq_w[k+1]),
      .srem_o  (srem_w[k+1]),
      .sq_o    (sq_w[k+1])
    );
  end

  rgb2hsv_fix #(.CHANNEL_BITS(CHANNEL_BITS)) u_fix (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (valid_w[NSTEP]),
    .ready_o (ready_w[NSTEP]),
    .ctl_i   (ctl_w[NSTEP]),
    .d_i     (d_w[NSTEP]),
    .mx_i    (mx_w[NSTEP]),
    .hrem_i  (hrem_w[NSTEP]),
    .hq_i    (hq_w[NSTEP]),
    .srem_i  (srem_w[NSTEP]),
    .sq_i    (sq_w[NSTEP]),
    .out_hsv (out_hsv)
  );

endmodule

### tb/rgb_to_hsv_converter_tb.sv
// Self-checking testbench of the RGB to HSV converter: random and corner pixels.
module rgb_to_hsv_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgb2hsv_pkg::*;

  localparam int unsigned CH_BITS = CHANNEL_BITS_DEF;
  localparam int unsigned CH_MAX  = (1 << CH_BITS) - 1;
  localparam int unsigned LATENCY = 3 + ((CH_BITS > HUE_Q_W) ? CH_BITS : HUE_Q_W);
  localparam int unsigned N_RANDOM = 1850;

  typedef logic [CH_BITS-1:0] chan_t;

  class hsv_scoreboard;
    typedef struct packed {
      logic [HUE_W-1:0] hue_degrees;
      logic [SAT_W-1:0] saturation;
    } hsv_t;

    hsv_t        hsv_q[$];
    int unsigned errors;
    int unsigned checked;

    function hsv_t hsv_of(chan_t red, chan_t green, chan_t blue);
      int      ri, gi, bi, hi, lo, delta, offset, diff, num, hue;
      sector_t sector;
      hsv_t    res;
      ri = red;
      gi = green;
      bi = blue;
      hi = ri;
      lo = ri;
      if (gi > hi) hi = gi;
      if (bi > hi) hi = bi;
      if (gi < lo) lo = gi;
      if (bi < lo) lo = bi;
      delta = hi - lo;
      res = '0;
      if (delta == 0) return res;
      // ties go to red, then green
      if (hi == ri) sector = SEC_RED;
      else if (hi == gi) sector = SEC_GREEN;
      else sector = SEC_BLUE;
      case (sector)
        SEC_RED: begin
          offset = int'(HUE_FULL);
          diff   = gi - bi;
        end
        SEC_GREEN: begin
          offset = int'(HUE_GREEN);
          diff   = bi - ri;
        end
        default: begin
          offset = int'(HUE_BLUE);
          diff   = ri - gi;
        end
      endcase
      num = offset * delta + int'(HUE_SCALE) * diff;
      if (num < 0) num = 0;
      hue = num / delta;
      if (hue >= int'(HUE_FULL)) hue = hue - int'(HUE_FULL);
      res.hue_degrees = hue[HUE_W-1:0];
      res.saturation  = SAT_W'((delta * int'(CH_MAX)) / hi);
      return res;
    endfunction

    function void note_pixel(chan_t red, chan_t green, chan_t blue);
      hsv_q.push_back(hsv_of(red, green, blue));
    endfunction

    function void check_result(logic [HUE_W-1:0] hue_degrees, logic [SAT_W-1:0] saturation);
      hsv_t exp_hsv;
      checked++;
      if (hsv_q.size() == 0) begin
        $error("unexpected result beat: hue_degrees %0d, saturation %0d",
               hue_degrees, saturation);
        errors++;
        return;
      end
      exp_hsv = hsv_q.pop_front();
      if (hue_degrees !== exp_hsv.hue_degrees) begin
        $error("hue_degrees mismatch: expected %0d, actual %0d",
               exp_hsv.hue_degrees, hue_degrees);
        errors++;
      end
      if (saturation !== exp_hsv.saturation) begin
        $error("saturation mismatch: expected %0d, actual %0d",
               exp_hsv.saturation, saturation);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return hsv_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rgb2hsv_rgb_if #(.CHANNEL_BITS(CH_BITS)) pix_if ();
  rgb2hsv_hs_if hsv_if ();

  hsv_scoreboard sb = new();

  rgb_to_hsv_converter #(.CHANNEL_BITS(CH_BITS)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_if.sink),
    .out_hsv (hsv_if.source)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // called at a rising edge; returns at the edge that takes the beat
  task automatic send_pixel(input chan_t red, input chan_t green, input chan_t blue);
    pix_if.valid <= 1'b1;
    pix_if.red   <= red;
    pix_if.green <= green;
    pix_if.blue  <= blue;
    do @(posedge clk); while (!pix_if.ready);
    sb.note_pixel(red, green, blue);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    if (cycles == 0) return;
    pix_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic chan_t rand_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return chan_t'(CH_MAX);
      2:       return chan_t'($urandom_range(0, 3));
      3:       return chan_t'(CH_MAX - $urandom_range(0, 3));
      default: return chan_t'($urandom_range(0, CH_MAX));
    endcase
  endfunction

  initial begin : stimulus
    chan_t       r, g, b;
    int unsigned burst_left;
    pix_if.valid = 1'b0;
    pix_if.red   = '0;
    pix_if.green = '0;
    pix_if.blue  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // gray pixels
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    // primaries and secondaries
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    // ties at the max below full scale
    send_pixel(8'd1, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd1);
    send_pixel(8'd1, 8'd0, 8'd1);
    // red sector just below the wrap
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd2, 8'd0, 8'd1);
    // smallest nonzero max, smallest delta
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd254);
    send_pixel(8'd254, 8'd254, 8'd255);
    // each sector with a positive difference, green and blue also with a negative one
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd50, 8'd200, 8'd100);
    send_pixel(8'd100, 8'd50, 8'd200);
    send_pixel(8'd100, 8'd200, 8'd50);
    send_pixel(8'd50, 8'd100, 8'd200);
    drain();

    burst_left = 0;
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
      end
      burst_left--;
      r = rand_level();
      g = rand_level();
      b = rand_level();
      case ($urandom_range(0, 19))
        0: begin
          g = r;
          b = r;
        end
        1: g = r;
        2: b = g;
        3: b = r;
        default: ;
      endcase
      send_pixel(r, g, b);
    end

    drain();
    repeat (3 * LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : result_sink
    int unsigned mode, mode_left, hold_left, phase;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    phase     = 0;
    hsv_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && hsv_if.valid && hsv_if.ready) begin
        sb.check_result(hsv_if.hue_degrees, hsv_if.saturation);
        // long hold-off so the pipeline fills and backs up the input
        if (sb.checked == 400 || sb.checked == 1300) hold_left = 250;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      phase++;
      if (hold_left != 0) begin
        hold_left--;
        hsv_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       hsv_if.ready <= 1'b1;
          1:       hsv_if.ready <= ($urandom_range(0, 1) == 1);
          2:       hsv_if.ready <= ($urandom_range(0, 9) != 0);
          default: hsv_if.ready <= ((phase % 7) >= 3);
        endcase
      end
    end
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/rgb2hsv_pkg.sv
rtl/core/rgb2hsv_ifs.sv
rtl/core/rgb2hsv_prep.sv
rtl/core/rgb2hsv_div_step.sv
rtl/core/rgb2hsv_fix.sv
rtl/core/rgb_to_hsv_converter.sv
tb/rgb_to_hsv_converter_tb.sv
